>>> rtl/uvsg_pkg.sv
// uv sphere vertex generator: shared widths, register codes, constants and types
// no dependencies; used by the interfaces, the sine/cosine pipeline and the top level
`default_nettype none

package uvsg_pkg;

	// segment limits and field widths
	localparam int MAX_SEGMENTS = 256;
	localparam int IDX_W        = 9;
	localparam int POS_W        = 17;
	localparam int LVL_W        = 8;
	localparam int VIDX_W       = 17;
	localparam int RADIUS_W     = 16;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 16;

	// configuration register codes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RADIUS  = 2'd0,
		CFG_SECTORS = 2'd1,
		CFG_STACKS  = 2'd2
	} cfg_reg_t;

	localparam logic [RADIUS_W-1:0] RADIUS_RST  = 16'd256;
	localparam logic [IDX_W-1:0]    SECTORS_RST = 9'd36;
	localparam logic [IDX_W-1:0]    STACKS_RST  = 9'd18;

	// phase in 2^-24 turn, octant angle up to 2^21
	localparam int PHASE_W = 24;
	localparam int ANG_W   = 22;

	// q30 fixed point
	localparam int T_W    = 30;
	localparam int Q30_W  = 31;
	localparam int MAG_W  = 16;
	localparam int TRIG_W = 17;
	localparam logic [Q30_W-1:0] ONE_Q30 = 31'h4000_0000;
	localparam logic [31:0]      PI_Q30  = 32'd3373259426;

	// phase divider: four quotient bits per stage
	localparam int DIV_BITS  = 4;
	localparam int NUM_W     = 36;
	localparam int DIV_STEPS = NUM_W / DIV_BITS;
	localparam int REM_W     = 8;

	// horner series: divisors and 2^32/d reciprocals
	localparam int HORNER = 4;
	localparam logic [6:0] SIN_DIV [HORNER] = '{7'd72, 7'd42, 7'd20, 7'd6};
	localparam logic [6:0] COS_DIV [HORNER] = '{7'd56, 7'd30, 7'd12, 7'd2};
	localparam logic [31:0] SIN_RCP [HORNER] = '{
		32'((64'd1 << 32) / 64'd72), 32'((64'd1 << 32) / 64'd42),
		32'((64'd1 << 32) / 64'd20), 32'((64'd1 << 32) / 64'd6)};
	localparam logic [31:0] COS_RCP [HORNER] = '{
		32'((64'd1 << 32) / 64'd56), 32'((64'd1 << 32) / 64'd30),
		32'((64'd1 << 32) / 64'd12), 32'((64'd1 << 32) / 64'd2)};

	// sine/cosine pipeline stages: t, t^2, three stages per horner round, output
	localparam int SC_LAT   = 2 + 3 * HORNER + 1;
	localparam int FOLD     = DIV_STEPS + 1;
	localparam int PIPE_LEN = FOLD + SC_LAT + 1 + 4 + 1;

	// octant folding info of one phase
	typedef struct packed {
		logic [1:0] quad;
		logic       swap;
	} oct_t;

	typedef struct packed {
		oct_t             oct;
		logic [ANG_W-1:0] ang;
	} fold_t;

	// signed q15 sine and cosine
	typedef struct packed {
		logic signed [TRIG_W-1:0] s;
		logic signed [TRIG_W-1:0] c;
	} trig_t;

	// per-vertex index and flag fields carried along the pipeline
	typedef struct packed {
		logic [VIDX_W-1:0] tl;
		logic [VIDX_W-1:0] bl;
		logic              qv;
		logic              pir;
	} vtx_tag_t;

endpackage

`default_nettype wire

>>> rtl/uvsg_ifs.sv
// uv sphere vertex generator: grid point and vertex channel interfaces
// depends on uvsg_pkg
`default_nettype none

interface uvsg_grid_if;
	import uvsg_pkg::*;
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] stack_index;
	logic [IDX_W-1:0] sector_index;
	modport source (output valid, stack_index, sector_index, input ready);
	modport sink (input valid, stack_index, sector_index, output ready);
endinterface

interface uvsg_vertex_if;
	import uvsg_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [POS_W-1:0]  pos_x;
	logic signed [POS_W-1:0]  pos_y;
	logic signed [POS_W-1:0]  pos_z;
	logic [LVL_W-1:0]         red_level;
	logic [LVL_W-1:0]         green_level;
	logic [LVL_W-1:0]         blue_level;
	logic [VIDX_W-1:0]        top_left_index;
	logic [VIDX_W-1:0]        bottom_left_index;
	logic                     quad_valid;
	logic                     point_in_range;
	modport source (output valid, pos_x, pos_y, pos_z, red_level, green_level, blue_level,
		top_left_index, bottom_left_index, quad_valid, point_in_range, input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, red_level, green_level, blue_level,
		top_left_index, bottom_left_index, quad_valid, point_in_range, output ready);
endinterface

`default_nettype wire

>>> rtl/uvsg_sincos.sv
// uv sphere vertex generator: pipelined q15 sine and cosine of an octant angle
// depends on uvsg_pkg; all stages advance only while en is high
`default_nettype none

module uvsg_sincos (
	input  logic                       clk,
	input  logic                       en,
	input  logic [uvsg_pkg::ANG_W-1:0] ang,
	output logic [uvsg_pkg::MAG_W-1:0] sin_mag,
	output logic [uvsg_pkg::MAG_W-1:0] cos_mag
);
	import uvsg_pkg::*;

	// k' = 1 - p/d, with p/d from a reciprocal estimate and one correction
	function automatic logic [Q30_W-1:0] horner_next(logic [T_W-1:0] p, logic [T_W-1:0] q0,
			logic [6:0] d);
		logic [T_W-1:0] r;
		logic [T_W-1:0] q;
		r = p - T_W'(q0 * T_W'(d));
		q = (r >= T_W'(d)) ? q0 + 1'b1 : q0;
		return ONE_Q30 - Q30_W'(q);
	endfunction

	logic [T_W-1:0]   t_s1;
	logic [T_W-1:0]   t_s2, t2_s2;
	logic [T_W-1:0]   t_a [HORNER], t2_a [HORNER], sp_a [HORNER], cp_a [HORNER];
	logic [T_W-1:0]   t_b [HORNER], t2_b [HORNER], sp_b [HORNER], cp_b [HORNER];
	logic [T_W-1:0]   sq_b [HORNER], cq_b [HORNER];
	logic [T_W-1:0]   t_c [HORNER], t2_c [HORNER];
	logic [Q30_W-1:0] sk_c [HORNER], ck_c [HORNER];
	logic [T_W-1:0]   t_in [HORNER], t2_in [HORNER];
	logic [Q30_W-1:0] sk_in [HORNER], ck_in [HORNER];
	logic [60:0]      sv;

	// round inputs: first round starts from k = 1
	always_comb begin
		for (int j = 0; j < HORNER; j++) begin
			if (j == 0) begin
				t_in[j]  = t_s2;
				t2_in[j] = t2_s2;
				sk_in[j] = ONE_Q30;
				ck_in[j] = ONE_Q30;
			end else begin
				t_in[j]  = t_c[j-1];
				t2_in[j] = t2_c[j-1];
				sk_in[j] = sk_c[j-1];
				ck_in[j] = ck_c[j-1];
			end
		end
	end

	// angle in q30 radians and its square
	always_ff @(posedge clk) begin
		if (en) begin
			t_s1  <= T_W'((54'(ang) * 54'(PI_Q30) + 54'(1 << 22)) >> 23);
			t_s2  <= t_s1;
			t2_s2 <= T_W'((60'(t_s1) * 60'(t_s1)) >> 30);
		end
	end

	// horner rounds: product, reciprocal estimate, correction
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < HORNER; j++) begin
				t_a[j]  <= t_in[j];
				t2_a[j] <= t2_in[j];
				sp_a[j] <= T_W'((61'(t2_in[j]) * 61'(sk_in[j])) >> 30);
				cp_a[j] <= T_W'((61'(t2_in[j]) * 61'(ck_in[j])) >> 30);
				t_b[j]  <= t_a[j];
				t2_b[j] <= t2_a[j];
				sp_b[j] <= sp_a[j];
				cp_b[j] <= cp_a[j];
				sq_b[j] <= T_W'((62'(sp_a[j]) * 62'(SIN_RCP[j])) >> 32);
				cq_b[j] <= T_W'((62'(cp_a[j]) * 62'(COS_RCP[j])) >> 32);
				t_c[j]  <= t_b[j];
				t2_c[j] <= t2_b[j];
				sk_c[j] <= horner_next(sp_b[j], sq_b[j], SIN_DIV[j]);
				ck_c[j] <= horner_next(cp_b[j], cq_b[j], COS_DIV[j]);
			end
		end
	end

	// final sine product and rounding to q15
	assign sv = (61'(t_c[HORNER-1]) * 61'(sk_c[HORNER-1])) >> 30;

	always_ff @(posedge clk) begin
		if (en) begin
			sin_mag <= MAG_W'((sv + 61'(1 << 14)) >> 15);
			cos_mag <= MAG_W'((32'(ck_c[HORNER-1]) + 32'(1 << 14)) >> 15);
		end
	end

endmodule

`default_nettype wire

>>> rtl/uv_sphere_vertex_generator_unit.sv
// throughput: one vertex per cycle; the pipeline moves as one and holds on output stall
// phase divider takes 9 stages, sine/cosine pipeline 15, radius and ring products 4
// reset: asynchronous, active low; clears valid bits and loads radius 256, 36 sectors,
// 18 stacks
// depends on uvsg_pkg, uvsg_ifs and uvsg_sincos
`default_nettype none

module uv_sphere_vertex_generator_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [uvsg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [uvsg_pkg::CFG_DATA_W-1:0] cfg_data,
	uvsg_grid_if.sink                       grid,
	uvsg_vertex_if.source                   vertex
);
	import uvsg_pkg::*;

	// one restoring division step of four quotient bits
	function automatic logic [REM_W+DIV_BITS-1:0] div_step(logic [REM_W-1:0] rem,
			logic [DIV_BITS-1:0] nib, logic [IDX_W-1:0] d);
		logic [IDX_W-1:0]    r;
		logic [DIV_BITS-1:0] q;
		r = {1'b0, rem};
		for (int b = DIV_BITS - 1; b >= 0; b--) begin
			r = {r[REM_W-1:0], nib[b]};
			if (r >= d) begin
				r    = r - d;
				q[b] = 1'b1;
			end else begin
				q[b] = 1'b0;
			end
		end
		return {r[REM_W-1:0], q};
	endfunction

	// fold a phase into an octant angle
	function automatic fold_t fold_phase(logic [PHASE_W-1:0] p);
		fold_t            f;
		logic [ANG_W-1:0] u;
		u          = p[ANG_W-1:0];
		f.oct.quad = p[PHASE_W-1:ANG_W];
		if (u > ANG_W'(1 << 21)) begin
			f.oct.swap = 1'b1;
			f.ang      = ANG_W'(23'(1 << 22) - 23'(u));
		end else begin
			f.oct.swap = 1'b0;
			f.ang      = u;
		end
		return f;
	endfunction

	// rebuild signed sine and cosine from octant magnitudes
	function automatic trig_t unfold(oct_t o, logic [MAG_W-1:0] sm, logic [MAG_W-1:0] cm);
		trig_t                    t;
		logic signed [TRIG_W-1:0] s0, c0;
		s0 = o.swap ? $signed({1'b0, cm}) : $signed({1'b0, sm});
		c0 = o.swap ? $signed({1'b0, sm}) : $signed({1'b0, cm});
		case (o.quad)
			2'd0: begin t.s = s0; t.c = c0; end
			2'd1: begin t.s = c0; t.c = -s0; end
			2'd2: begin t.s = -s0; t.c = -c0; end
			default: begin t.s = -c0; t.c = s0; end
		endcase
		return t;
	endfunction

	// q15 product rounding, halves away from zero
	function automatic logic signed [POS_W-1:0] rnd_q15(logic signed [33:0] p);
		logic [33:0] m;
		logic [33:0] r;
		m = p[33] ? 34'(-p) : 34'(p);
		r = (m + 34'd16384) >> 15;
		return p[33] ? -POS_W'(r) : POS_W'(r);
	endfunction

	logic [RADIUS_W-1:0] radius_q;
	logic [IDX_W-1:0]    sectors_q, stacks_q;
	logic [RADIUS_W-1:0] r_eff;
	logic [IDX_W-1:0]    nsec, nstk;
	logic                en;
	vtx_tag_t            tag_in;

	logic                vld_s [PIPE_LEN];
	vtx_tag_t            tag_s [PIPE_LEN];

	logic [IDX_W-1:0]          stk_s [DIV_STEPS], sec_s [DIV_STEPS];
	logic [REM_W-1:0]          srem_s [DIV_STEPS], crem_s [DIV_STEPS];
	logic [PHASE_W-1:0]        sq_s [DIV_STEPS+1], cq_s [DIV_STEPS+1];
	logic [REM_W+DIV_BITS-1:0] sstep [DIV_STEPS], cstep [DIV_STEPS];

	fold_t               sfold, cfold;
	logic [ANG_W-1:0]    sang_f, cang_f;
	oct_t                soct_s [SC_LAT+1], coct_s [SC_LAT+1];
	logic [MAG_W-1:0]    ssin, scos, csin, ccos;
	trig_t               st, ct;

	logic signed [TRIG_W-1:0] ss_p1, sc_p1, cs_p1, cc_p1;
	logic signed [33:0]       py_m1, pring_m1;
	logic [26:0]              vr_m1;
	logic [31:0]              vg_m1;
	logic signed [TRIG_W-1:0] cs_m1, cc_m1, cs_m2, cc_m2;
	logic signed [POS_W-1:0]  y_m2, ring_m2, y_m3, y_m4, x_m4, z_m4;
	logic [LVL_W-1:0]         red_m2, green_m2, red_m3, green_m3, red_m4, green_m4;
	logic signed [33:0]       px_m3, pz_m3;
	logic [TRIG_W-1:0]        hs;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q  <= RADIUS_RST;
			sectors_q <= SECTORS_RST;
			stacks_q  <= STACKS_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_RADIUS:  radius_q  <= cfg_data[RADIUS_W-1:0];
				CFG_SECTORS: sectors_q <= cfg_data[IDX_W-1:0];
				CFG_STACKS:  stacks_q  <= cfg_data[IDX_W-1:0];
				default: ;
			endcase
		end
	end

	// effective radius and clamped segment counts
	always_comb begin
		r_eff = (radius_q == '0) ? RADIUS_W'(1) : radius_q;
		if (sectors_q < IDX_W'(3))
			nsec = IDX_W'(3);
		else if (sectors_q > IDX_W'(MAX_SEGMENTS))
			nsec = IDX_W'(MAX_SEGMENTS);
		else
			nsec = sectors_q;
		if (stacks_q < IDX_W'(2))
			nstk = IDX_W'(2);
		else if (stacks_q > IDX_W'(MAX_SEGMENTS))
			nstk = IDX_W'(MAX_SEGMENTS);
		else
			nstk = stacks_q;
	end

	// pipeline advances unless the output holds an untaken vertex
	assign en         = !vld_s[PIPE_LEN-1] || vertex.ready;
	assign grid.ready = en;

	// quad indices and range flags at entry
	always_comb begin
		tag_in.tl  = VIDX_W'(19'(grid.stack_index) * 19'(10'(nsec) + 10'd1)
			+ 19'(grid.sector_index));
		tag_in.bl  = tag_in.tl + VIDX_W'(nsec) + VIDX_W'(1);
		tag_in.qv  = (grid.stack_index < nstk) && (grid.sector_index < nsec);
		tag_in.pir = (grid.stack_index <= nstk) && (grid.sector_index <= nsec);
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PIPE_LEN; i++)
				vld_s[i] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= grid.valid;
			for (int i = 1; i < PIPE_LEN; i++)
				vld_s[i] <= vld_s[i-1];
		end
	end

	// index and flag fields follow the item
	always_ff @(posedge clk) begin
		if (en) begin
			tag_s[0] <= tag_in;
			for (int i = 1; i < PIPE_LEN; i++)
				tag_s[i] <= tag_s[i-1];
		end
	end

	// phase divider steps; numerators rebuilt from the carried indices
	always_comb begin
		logic [NUM_W-1:0] snum, cnum;
		for (int i = 0; i < DIV_STEPS; i++) begin
			snum     = (NUM_W'(stk_s[i]) << 23) | NUM_W'(nstk >> 1);
			cnum     = (NUM_W'(sec_s[i]) << 24) | NUM_W'(nsec >> 1);
			sstep[i] = div_step(srem_s[i], snum[NUM_W-1-DIV_BITS*i -: DIV_BITS], nstk);
			cstep[i] = div_step(crem_s[i], cnum[NUM_W-1-DIV_BITS*i -: DIV_BITS], nsec);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stk_s[0]  <= grid.stack_index;
			sec_s[0]  <= grid.sector_index;
			srem_s[0] <= '0;
			crem_s[0] <= '0;
			sq_s[0]   <= '0;
			cq_s[0]   <= '0;
			for (int i = 0; i < DIV_STEPS; i++) begin
				if (i < DIV_STEPS - 1) begin
					stk_s[i+1]  <= stk_s[i];
					sec_s[i+1]  <= sec_s[i];
					srem_s[i+1] <= sstep[i][REM_W+DIV_BITS-1:DIV_BITS];
					crem_s[i+1] <= cstep[i][REM_W+DIV_BITS-1:DIV_BITS];
				end
				sq_s[i+1] <= {sq_s[i][PHASE_W-DIV_BITS-1:0], sstep[i][DIV_BITS-1:0]};
				cq_s[i+1] <= {cq_s[i][PHASE_W-DIV_BITS-1:0], cstep[i][DIV_BITS-1:0]};
			end
		end
	end

	// stack phase is a quarter turn minus the quotient; fold both phases
	assign sfold = fold_phase(PHASE_W'(1 << 22) - sq_s[DIV_STEPS]);
	assign cfold = fold_phase(cq_s[DIV_STEPS]);

	always_ff @(posedge clk) begin
		if (en) begin
			sang_f    <= sfold.ang;
			cang_f    <= cfold.ang;
			soct_s[0] <= sfold.oct;
			coct_s[0] <= cfold.oct;
			for (int i = 1; i <= SC_LAT; i++) begin
				soct_s[i] <= soct_s[i-1];
				coct_s[i] <= coct_s[i-1];
			end
		end
	end

	// sine and cosine of stack and sector angles
	uvsg_sincos u_stack_trig (
		.clk     (clk),
		.en      (en),
		.ang     (sang_f),
		.sin_mag (ssin),
		.cos_mag (scos)
	);

	uvsg_sincos u_sector_trig (
		.clk     (clk),
		.en      (en),
		.ang     (cang_f),
		.sin_mag (csin),
		.cos_mag (ccos)
	);

	assign st = unfold(soct_s[SC_LAT], ssin, scos);
	assign ct = unfold(coct_s[SC_LAT], csin, ccos);

	always_ff @(posedge clk) begin
		if (en) begin
			ss_p1 <= st.s;
			sc_p1 <= st.c;
			cs_p1 <= ct.s;
			cc_p1 <= ct.c;
		end
	end

	// radius products and colour sums
	assign hs = TRIG_W'(ss_p1) + TRIG_W'(32768);

	always_ff @(posedge clk) begin
		if (en) begin
			py_m1    <= $signed({1'b0, r_eff}) * ss_p1;
			pring_m1 <= $signed({1'b0, r_eff}) * sc_p1;
			vr_m1    <= 27'd20381696 + 27'(hs) * 27'd459;
			vg_m1    <= 32'd922419200 + 32'(hs) * 32'd8925;
			cs_m1    <= cs_p1;
			cc_m1    <= cc_p1;
		end
	end

	// rounding and colour division by constants
	always_ff @(posedge clk) begin
		if (en) begin
			y_m2     <= rnd_q15(py_m1);
			ring_m2  <= rnd_q15(pring_m1);
			red_m2   <= LVL_W'((19'(vr_m1[26:16]) * 19'd205) >> 11);
			green_m2 <= LVL_W'((35'(vg_m1[30:16]) * 35'd5243) >> 19);
			cs_m2    <= cs_m1;
			cc_m2    <= cc_m1;
		end
	end

	// ring products
	always_ff @(posedge clk) begin
		if (en) begin
			px_m3    <= ring_m2 * cc_m2;
			pz_m3    <= ring_m2 * cs_m2;
			y_m3     <= y_m2;
			red_m3   <= red_m2;
			green_m3 <= green_m2;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			x_m4     <= rnd_q15(px_m3);
			z_m4     <= rnd_q15(pz_m3);
			y_m4     <= y_m3;
			red_m4   <= red_m3;
			green_m4 <= green_m3;
		end
	end

	// vertex channel
	assign vertex.valid             = vld_s[PIPE_LEN-1];
	assign vertex.pos_x             = x_m4;
	assign vertex.pos_y             = y_m4;
	assign vertex.pos_z             = z_m4;
	assign vertex.red_level         = red_m4;
	assign vertex.green_level       = green_m4;
	assign vertex.blue_level        = LVL_W'(255);
	assign vertex.top_left_index    = tag_s[PIPE_LEN-1].tl;
	assign vertex.bottom_left_index = tag_s[PIPE_LEN-1].bl;
	assign vertex.quad_valid        = tag_s[PIPE_LEN-1].qv;
	assign vertex.point_in_range    = tag_s[PIPE_LEN-1].pir;

endmodule

`default_nettype wire
